@@ hw/rtl/pyt_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pyt_pkg
// Shared types, widths and constants of the pythagoras tree branch block.
// ---------------------------------------------------------------------------
package pyt_pkg;

  // defaults of the top-level parameters
  localparam int COORD_WIDTH_DEF  = 32;
  localparam int CORDIC_STEPS_DEF = 16;

  // internal widths
  localparam int DW = 33;  // corner difference
  localparam int QW = 32;  // clamped Q2.30 values
  localparam int VW = 36;  // vectoring cordic datapath
  localparam int RW = 34;  // rotation cordic datapath
  localparam int ZW = 32;  // Q8.24 angles
  localparam int UW = 36;  // rounded products, integer or Q2.30
  localparam int PW = 66;  // first product rank
  localparam int MW = 72;  // second product rank
  localparam int CW = 42;  // final coordinates before saturation

  localparam logic signed [RW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [QW-1:0] ONE_Q30     = 32'sd1073741824;
  localparam logic signed [ZW-1:0] HALF_PI_Q24 = 32'sd26353589;
  localparam logic [26:0]          DEG_TO_RAD  = 27'd74961321;
  localparam logic [14:0]          ANGLE_MIN   = 15'd256;
  localparam logic [14:0]          ANGLE_MAX   = 15'd22784;
  localparam logic [14:0]          ANGLE_RESET = 15'd11520;

  // arctangent of 2^-i, Q8.24 radians
  function automatic logic signed [ZW-1:0] atan_q24(input int unsigned i);
    case (i)
      0:  return 32'sd13176795;
      1:  return 32'sd7778716;
      2:  return 32'sd4110060;
      3:  return 32'sd2086331;
      4:  return 32'sd1047214;
      5:  return 32'sd524117;
      6:  return 32'sd262123;
      7:  return 32'sd131069;
      8:  return 32'sd65536;
      9:  return 32'sd32768;
      10: return 32'sd16384;
      11: return 32'sd8192;
      12: return 32'sd4096;
      13: return 32'sd2048;
      14: return 32'sd1024;
      15: return 32'sd512;
      16: return 32'sd256;
      17: return 32'sd128;
      18: return 32'sd64;
      19: return 32'sd32;
      20: return 32'sd16;
      21: return 32'sd8;
      22: return 32'sd4;
      23: return 32'sd2;
      default: return '0;
    endcase
  endfunction

  // parent square word
  typedef struct packed {
    logic signed [31:0] corner_a_x;
    logic signed [31:0] corner_a_y;
    logic signed [31:0] corner_b_x;
    logic signed [31:0] corner_b_y;
    logic        [31:0] side_len;
    logic signed [31:0] rotation_in;
    logic        [7:0]  generation_in;
  } parent_t;

  // child square word
  typedef struct packed {
    logic signed [31:0] apex_x;
    logic signed [31:0] apex_y;
    logic signed [31:0] far_a_x;
    logic signed [31:0] far_a_y;
    logic signed [31:0] far_b_x;
    logic signed [31:0] far_b_y;
    logic        [31:0] child_side;
    logic signed [31:0] child_rotation;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic        [7:0]  child_generation;
    logic               is_last;
  } child_t;

  // parent data carried alongside the cordic stages
  typedef struct packed {
    logic signed [31:0]   ax;
    logic signed [31:0]   ay;
    logic signed [31:0]   bx;
    logic signed [31:0]   by;
    logic        [31:0]   side;
    logic signed [31:0]   rot;
    logic        [7:0]    gen;
    logic signed [ZW-1:0] theta;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic                 flip;
    logic                 zero;
  } path_t;

  // both children of one parent, before saturation
  typedef struct packed {
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic signed [CW-1:0] r_fa_x;
    logic signed [CW-1:0] r_fa_y;
    logic signed [CW-1:0] r_fb_x;
    logic signed [CW-1:0] r_fb_y;
    logic signed [CW-1:0] r_c_x;
    logic signed [CW-1:0] r_c_y;
    logic signed [CW-1:0] l_fa_x;
    logic signed [CW-1:0] l_fa_y;
    logic signed [CW-1:0] l_fb_x;
    logic signed [CW-1:0] l_fb_y;
    logic signed [CW-1:0] l_c_x;
    logic signed [CW-1:0] l_c_y;
    logic        [31:0]   r_side;
    logic        [31:0]   l_side;
    logic signed [31:0]   r_rot;
    logic signed [31:0]   l_rot;
    logic        [7:0]    gen;
  } pair_t;

  // output phase
  typedef enum logic [1:0] {
    PH_RIGHT = 2'b01,
    PH_LEFT  = 2'b10
  } phase_t;

endpackage

@@ hw/rtl/pythagoras_tree_branch.sv @@
`timescale 1ns / 1ps
// The right child word is shown after the input stage, the vectoring cordic,
// the rotation cordics, the math stages and the output register; the left
// child word follows once the right one is taken. The single-word output port
// carries both child words of a parent, so the pipeline holds until both are loaded.
// Reset: rst is synchronous; it empties the pipeline and output register and
// sets the branch angle to 45 degrees.
// ---------------------------------------------------------------------------
// pythagoras_tree_branch
// Pipelined branch step: parent square in, right and left child squares out.
// ---------------------------------------------------------------------------
module pythagoras_tree_branch import pyt_pkg::*; #(
  parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        parent_valid,
  output logic        parent_stall,
  input  parent_t     parent,
  output logic        child_valid,
  input  logic        child_stall,
  output child_t      child,
  input  logic        angle_valid,
  output logic        angle_ready,
  input  logic [14:0] angle_data
);

  localparam int CWE = (COORD_WIDTH < CW) ? COORD_WIDTH : CW;

  // saturate a coordinate to COORD_WIDTH bits, then keep the 32-bit field
  function automatic logic signed [31:0] sat_coord(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] hi;
    logic signed [CW-1:0] lo;
    hi = {{(CW-CWE+1){1'b0}}, {(CWE-1){1'b1}}};
    lo = ~hi;
    if (v > hi) return hi[31:0];
    else if (v < lo) return lo[31:0];
    else return v[31:0];
  endfunction

  logic        adv;
  logic [14:0] branch_angle;

  // configuration register
  assign angle_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      branch_angle <= ANGLE_RESET;
    end else if (angle_valid && angle_ready) begin
      branch_angle <= angle_data;
    end
  end

  // input stage: edge vector, branch angle in radians
  logic [14:0]          deg;
  logic [42:0]          theta_prod;
  logic signed [DW-1:0] dx, dy;
  path_t                s0_path;
  logic                 s0_valid;
  logic signed [VW-1:0] s0_vx, s0_vy;

  always_comb begin
    if (branch_angle < ANGLE_MIN) deg = ANGLE_MIN;
    else if (branch_angle > ANGLE_MAX) deg = ANGLE_MAX;
    else deg = branch_angle;
    theta_prod = 43'(deg) * 43'(DEG_TO_RAD) + 43'd32768;
    dx = DW'(parent.corner_b_x) - DW'(parent.corner_a_x);
    dy = DW'(parent.corner_b_y) - DW'(parent.corner_a_y);
  end

  assign parent_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= parent_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_path.ax    <= parent.corner_a_x;
      s0_path.ay    <= parent.corner_a_y;
      s0_path.bx    <= parent.corner_b_x;
      s0_path.by    <= parent.corner_b_y;
      s0_path.side  <= parent.side_len;
      s0_path.rot   <= parent.rotation_in;
      s0_path.gen   <= parent.generation_in;
      s0_path.theta <= $signed({6'd0, theta_prod[41:16]});
      s0_path.dx    <= dx;
      s0_path.dy    <= dy;
      s0_path.flip  <= dx[DW-1];
      s0_path.zero  <= (dx == '0) && (dy == '0);
      s0_vx         <= dx[DW-1] ? -VW'(dx) : VW'(dx);
      s0_vy         <= dx[DW-1] ? -VW'(dy) : VW'(dy);
    end
  end

  // edge angle by vectoring, parent data alongside
  logic signed [ZW-1:0] phi;
  logic                 a_valid;
  logic [$bits(path_t)-1:0] a_bits;
  path_t                a_path;

  pyt_cordic #(.STEPS(CORDIC_STEPS), .XW(VW), .VECTOR(1'b1)) u_vec (
    .clk   (clk),
    .en    (adv),
    .x_in  (s0_vx),
    .y_in  (s0_vy),
    .z_in  ('0),
    .x_out (),
    .y_out (),
    .z_out (phi)
  );

  pyt_delay #(.W($bits(path_t)), .DEPTH(CORDIC_STEPS)) u_dly_a (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .vld_in  (s0_valid),
    .d_in    (s0_path),
    .vld_out (a_valid),
    .d_out   (a_bits)
  );

  assign a_path = path_t'(a_bits);

  // unit edge direction and cos/sin of the branch angle
  logic signed [RW-1:0] ex, ey, cs_c, cs_s;
  logic                 b_valid;
  logic [$bits(path_t)-1:0] b_bits;

  pyt_cordic #(.STEPS(CORDIC_STEPS), .XW(RW), .VECTOR(1'b0)) u_rot_edge (
    .clk   (clk),
    .en    (adv),
    .x_in  (CORDIC_GAIN),
    .y_in  ('0),
    .z_in  (phi),
    .x_out (ex),
    .y_out (ey),
    .z_out ()
  );

  pyt_cordic #(.STEPS(CORDIC_STEPS), .XW(RW), .VECTOR(1'b0)) u_rot_angle (
    .clk   (clk),
    .en    (adv),
    .x_in  (CORDIC_GAIN),
    .y_in  ('0),
    .z_in  (a_path.theta),
    .x_out (cs_c),
    .y_out (cs_s),
    .z_out ()
  );

  pyt_delay #(.W($bits(path_t)), .DEPTH(CORDIC_STEPS)) u_dly_b (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .vld_in  (a_valid),
    .d_in    (a_bits),
    .vld_out (b_valid),
    .d_out   (b_bits)
  );

  // geometry
  logic  last_valid;
  pair_t pair;

  pyt_math u_math (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .vld_in   (b_valid),
    .path_in  (path_t'(b_bits)),
    .c_in     (cs_c),
    .s_in     (cs_s),
    .ex_in    (ex),
    .ey_in    (ey),
    .vld_out  (last_valid),
    .pair_out (pair)
  );

  // output: right child word, then left child word
  phase_t phase;
  logic   load;
  child_t word_next;

  assign load = !child_valid || !child_stall;
  assign adv  = !last_valid || (load && (phase == PH_LEFT));

  always_comb begin
    word_next.apex_x           = sat_coord(pair.px);
    word_next.apex_y           = sat_coord(pair.py);
    word_next.child_generation = pair.gen;
    if (phase == PH_LEFT) begin
      word_next.far_a_x        = sat_coord(pair.l_fa_x);
      word_next.far_a_y        = sat_coord(pair.l_fa_y);
      word_next.far_b_x        = sat_coord(pair.l_fb_x);
      word_next.far_b_y        = sat_coord(pair.l_fb_y);
      word_next.child_side     = pair.l_side;
      word_next.child_rotation = pair.l_rot;
      word_next.center_x       = sat_coord(pair.l_c_x);
      word_next.center_y       = sat_coord(pair.l_c_y);
      word_next.is_last        = 1'b1;
    end else begin
      word_next.far_a_x        = sat_coord(pair.r_fa_x);
      word_next.far_a_y        = sat_coord(pair.r_fa_y);
      word_next.far_b_x        = sat_coord(pair.r_fb_x);
      word_next.far_b_y        = sat_coord(pair.r_fb_y);
      word_next.child_side     = pair.r_side;
      word_next.child_rotation = pair.r_rot;
      word_next.center_x       = sat_coord(pair.r_c_x);
      word_next.center_y       = sat_coord(pair.r_c_y);
      word_next.is_last        = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      child_valid <= 1'b0;
      phase       <= PH_RIGHT;
    end else if (load) begin
      child_valid <= last_valid;
      if (last_valid) begin
        case (phase)
          PH_RIGHT: phase <= PH_LEFT;
          PH_LEFT:  phase <= PH_RIGHT;
          default:  phase <= PH_RIGHT;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && last_valid) begin
      child <= word_next;
    end
  end

  // a taken right word is followed at once by its left word
  assert property (@(posedge clk) disable iff (rst)
    (child_valid && !child_stall && !child.is_last) |=> (child_valid && child.is_last))
    else $error("left child word did not follow right child word");

  // both words of one parent share the apex
  assert property (@(posedge clk) disable iff (rst)
    (child_valid && !child_stall && !child.is_last) |=>
      (child.apex_x == $past(child.apex_x) && child.apex_y == $past(child.apex_y)))
    else $error("apex changed between the two children of one parent");

  // the pipeline only moves once the finished parent has given both words
  assert property (@(posedge clk) disable iff (rst)
    (last_valid && adv) |-> (load && phase == PH_LEFT))
    else $error("parent dropped before both children were sent");

  // generation is incremented, never zero on the output
  assert property (@(posedge clk) disable iff (rst)
    child_valid |-> (child.child_generation != 8'd0))
    else $error("child generation is zero");

endmodule

@@ hw/rtl/pyt_delay.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pyt_delay
// Enabled shift line with a valid bit, keeps data aligned with a pipeline.
// ---------------------------------------------------------------------------
module pyt_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         vld_in,
  input  logic [W-1:0] d_in,
  output logic         vld_out,
  output logic [W-1:0] d_out
);

  logic [DEPTH-1:0] vld;
  logic [W-1:0]     data [DEPTH];

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld[0] <= vld_in;
      for (int i = 1; i < DEPTH; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  // data chain
  always_ff @(posedge clk) begin
    if (en) begin
      data[0] <= d_in;
      for (int i = 1; i < DEPTH; i++) begin
        data[i] <= data[i-1];
      end
    end
  end

  assign vld_out = vld[DEPTH-1];
  assign d_out   = data[DEPTH-1];

endmodule

@@ hw/rtl/pyt_cordic.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pyt_cordic
// Pipelined cordic, one register stage per iteration, rotation or vectoring.
// ---------------------------------------------------------------------------
module pyt_cordic import pyt_pkg::*; #(
  parameter int STEPS  = CORDIC_STEPS_DEF,
  parameter int XW     = VW,
  parameter bit VECTOR = 1'b0
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [XW-1:0] x_in,
  input  logic signed [XW-1:0] y_in,
  input  logic signed [ZW-1:0] z_in,
  output logic signed [XW-1:0] x_out,
  output logic signed [XW-1:0] y_out,
  output logic signed [ZW-1:0] z_out
);

  logic signed [XW-1:0] xs [STEPS+1];
  logic signed [XW-1:0] ys [STEPS+1];
  logic signed [ZW-1:0] zs [STEPS+1];

  assign xs[0] = x_in;
  assign ys[0] = y_in;
  assign zs[0] = z_in;

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic cw;
    // clockwise micro-rotation: vectoring drives y to zero, rotation drives z
    assign cw = VECTOR ? !ys[i][XW-1] : zs[i][ZW-1];

    always_ff @(posedge clk) begin
      if (en) begin
        if (cw) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + atan_q24(i);
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - atan_q24(i);
        end
      end
    end
  end

  assign x_out = xs[STEPS];
  assign y_out = ys[STEPS];
  assign z_out = zs[STEPS];

endmodule

@@ hw/rtl/pyt_math.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pyt_math
// Six-stage multiply and add pipeline: apex, child directions, sizes,
// far corners, centers and rotations of both children.
// ---------------------------------------------------------------------------
module pyt_math import pyt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 vld_in,
  input  path_t                path_in,
  input  logic signed [RW-1:0] c_in,
  input  logic signed [RW-1:0] s_in,
  input  logic signed [RW-1:0] ex_in,
  input  logic signed [RW-1:0] ey_in,
  output logic                 vld_out,
  output pair_t                pair_out
);

  localparam logic signed [PW-1:0] HALF_P = PW'(64'sd536870912);
  localparam logic signed [MW-1:0] HALF_M = MW'(64'sd536870912);

  function automatic logic signed [QW-1:0] clamp_q30(input logic signed [RW:0] v,
                                                     input logic allow_neg);
    logic signed [RW:0] hi;
    logic signed [RW:0] lo;
    hi = (RW+1)'(ONE_Q30);
    lo = allow_neg ? -hi : '0;
    if (v > hi) return hi[QW-1:0];
    else if (v < lo) return lo[QW-1:0];
    else return v[QW-1:0];
  endfunction

  function automatic logic signed [CW-1:0] rnd_m(input logic signed [MW-1:0] v);
    logic signed [MW-1:0] t;
    t = v + HALF_M;
    return t[CW+29:30];
  endfunction

  function automatic logic signed [31:0] sat_rot(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'sh7fffffff;
    else if (v < -34'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  logic [5:0] vld;
  path_t p0, p1, p2, p3, p4;

  // stage 0: clamp cos, sin and the edge direction
  logic signed [RW:0]   ex_s, ey_s;
  logic signed [QW-1:0] c0, s0, ex0, ey0;

  always_comb begin
    ex_s = path_in.flip ? -(RW+1)'(ex_in) : (RW+1)'(ex_in);
    ey_s = path_in.flip ? -(RW+1)'(ey_in) : (RW+1)'(ey_in);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0 <= path_in;
      c0 <= clamp_q30((RW+1)'(c_in), 1'b0);
      s0 <= clamp_q30((RW+1)'(s_in), 1'b0);
      if (path_in.zero) begin
        ex0 <= ONE_Q30;
        ey0 <= '0;
      end else begin
        ex0 <= clamp_q30(ex_s, 1'b1);
        ey0 <= clamp_q30(ey_s, 1'b1);
      end
    end
  end

  // stage 1: first rank of products
  logic signed [QW-1:0] c1;
  logic signed [PW-1:0] cdx, sdy, sdx, cdy, cex, sey, sex, cey, sc, ss;
  logic signed [DW:0]   side0;

  assign side0 = $signed({2'b00, p0.side});

  always_ff @(posedge clk) begin
    if (en) begin
      p1  <= p0;
      c1  <= c0;
      cdx <= PW'(c0) * PW'(p0.dx);
      sdy <= PW'(s0) * PW'(p0.dy);
      sdx <= PW'(s0) * PW'(p0.dx);
      cdy <= PW'(c0) * PW'(p0.dy);
      cex <= PW'(c0) * PW'(ex0);
      sey <= PW'(s0) * PW'(ey0);
      sex <= PW'(s0) * PW'(ex0);
      cey <= PW'(c0) * PW'(ey0);
      sc  <= PW'(side0) * PW'(c0);
      ss  <= PW'(side0) * PW'(s0);
    end
  end

  // stage 2: rotate the edge and the direction; edge and sizes round to integers, the direction to Q2.30
  logic signed [PW-1:0] sum_ux, sum_uy, sum_d1x, sum_d1y, sum_z0, sum_z1;
  logic signed [QW-1:0] c2;
  logic signed [UW-1:0] ux, uy, d1x, d1y, size0, size1;

  always_comb begin
    sum_ux  = cdx - sdy + HALF_P;
    sum_uy  = sdx + cdy + HALF_P;
    sum_d1x = cex - sey + HALF_P;
    sum_d1y = sex + cey + HALF_P;
    sum_z0  = sc + HALF_P;
    sum_z1  = ss + HALF_P;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2    <= p1;
      c2    <= c1;
      ux    <= sum_ux[UW+29:30];
      uy    <= sum_uy[UW+29:30];
      d1x   <= sum_d1x[UW+29:30];
      d1y   <= sum_d1y[UW+29:30];
      size0 <= sum_z0[UW+29:30];
      size1 <= sum_z1[UW+29:30];
    end
  end

  // stage 3: second rank of products, d2 = (-d1y, d1x)
  logic signed [MW-1:0] cux, cuy, q0x, q0y, q1x, q1y;
  logic signed [UW-1:0] size0_3, size1_3;

  always_ff @(posedge clk) begin
    if (en) begin
      p3      <= p2;
      size0_3 <= size0;
      size1_3 <= size1;
      cux     <= MW'(c2) * MW'(ux);
      cuy     <= MW'(c2) * MW'(uy);
      q0x     <= -(MW'(d1y) * MW'(size0));
      q0y     <= MW'(d1x) * MW'(size0);
      q1x     <= MW'(d1x) * MW'(size1);
      q1y     <= MW'(d1y) * MW'(size1);
    end
  end

  // stage 4: apex and child offsets
  logic signed [CW-1:0] px, py, t0x, t0y, t1x, t1y;
  logic [31:0]          side_r4, side_l4;

  always_ff @(posedge clk) begin
    if (en) begin
      p4      <= p3;
      px      <= CW'(p3.ax) + rnd_m(cux);
      py      <= CW'(p3.ay) + rnd_m(cuy);
      t0x     <= rnd_m(q0x);
      t0y     <= rnd_m(q0y);
      t1x     <= rnd_m(q1x);
      t1y     <= rnd_m(q1y);
      side_r4 <= size0_3[31:0];
      side_l4 <= size1_3[31:0];
    end
  end

  // stage 5: far corners, centers and rotations
  logic signed [CW-1:0] ax5, ay5, bx5, by5, rcx, rcy, lcx, lcy;

  always_comb begin
    ax5 = CW'(p4.ax);
    ay5 = CW'(p4.ay);
    bx5 = CW'(p4.bx);
    by5 = CW'(p4.by);
    rcx = px + ax5 + t0x;
    rcy = py + ay5 + t0y;
    lcx = bx5 + px + t1x;
    lcy = by5 + py + t1y;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pair_out.px     <= px;
      pair_out.py     <= py;
      pair_out.r_fa_x <= ax5 + t0x;
      pair_out.r_fa_y <= ay5 + t0y;
      pair_out.r_fb_x <= px + t0x;
      pair_out.r_fb_y <= py + t0y;
      pair_out.r_c_x  <= rcx >>> 1;
      pair_out.r_c_y  <= rcy >>> 1;
      pair_out.l_fa_x <= px + t1x;
      pair_out.l_fa_y <= py + t1y;
      pair_out.l_fb_x <= bx5 + t1x;
      pair_out.l_fb_y <= by5 + t1y;
      pair_out.l_c_x  <= lcx >>> 1;
      pair_out.l_c_y  <= lcy >>> 1;
      pair_out.r_side <= side_r4;
      pair_out.l_side <= side_l4;
      pair_out.r_rot  <= sat_rot(34'(p4.rot) - 34'(p4.theta));
      pair_out.l_rot  <= sat_rot(34'(p4.rot) + 34'(HALF_PI_Q24) - 34'(p4.theta));
      pair_out.gen    <= (p4.gen == 8'hff) ? 8'hff : p4.gen + 8'd1;
    end
  end

  // valid bits travel with the stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[4:0], vld_in};
    end
  end

  assign vld_out = vld[5];

endmodule
